// ===== hdl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants for the MIDI/ASCII stream splitter.
// ----------------------------------------------------------------------------
package mss_pkg;

    // kind of event reported on the result stream
    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2,
        KIND_CTRL  = 2'd3
    } t_event_kind;

    // register index on the register port
    localparam logic [0:0] REG_CONTROL_CHANNEL = 1'b0;

    // high nibble of a status byte
    localparam logic [3:0] STATUS_NOTE_OFF  = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON   = 4'h9;
    localparam logic [3:0] STATUS_CTRL      = 4'hB;
    localparam logic [3:0] STATUS_CHAN_PRES = 4'hD;

    // message fill count
    localparam logic [1:0] FILL_IDLE   = 2'd0;
    localparam logic [1:0] FILL_STATUS = 2'd1;
    localparam logic [1:0] FILL_FIRST  = 2'd2;

    // one decoded event from the parser
    typedef struct packed {
        logic        valid;
        t_event_kind kind;
        logic [3:0]  channel;
        logic [6:0]  key_or_id;
        logic [6:0]  amount;
        logic [6:0]  text_char;
    } t_event;

endpackage

// ===== hdl/midi_stream_splitter.sv =====
// ----------------------------------------------------------------------------
// midi_stream_splitter
// Splits a received byte stream into MIDI note and controller events and
// pass-through ASCII characters. A byte enters an input register, is decoded
// against the held message state and lands in a result register, so one byte
// is taken every cycle and its event, if any, is offered on the output from
// the result register; the only stall is a full result register that is not
// being taken.
// Status bytes, incomplete messages and messages other than note on or note off
// on any channel and controller change on the configured channel give no event.
// ----------------------------------------------------------------------------
module midi_stream_splitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // event stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] channel, [10:4] key_or_id,
                                        // [17:11] amount, [24:18] text_char
    output logic [1:0]  m_axis_tuser,   // [1:0] event_kind
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_out_valid;
    mss_pkg::t_event r_out_event;
    logic [3:0]      r_control_channel;
    logic            advance;
    mss_pkg::t_event dec_event;

    // register port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control_channel <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mss_pkg::REG_CONTROL_CHANNEL) begin
            r_control_channel <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == mss_pkg::REG_CONTROL_CHANNEL) begin
            prdata = {28'd0, r_control_channel};
        end
    end

    // pipeline control: the input register moves on when the result slot is free or is being taken
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // decode
    mss_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_byte            (r_in_byte),
        .i_control_channel (r_control_channel),
        .o_event           (dec_event)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= advance && dec_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && dec_event.valid) begin
            r_out_event <= dec_event;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_event.kind;
    assign m_axis_tdata  = {7'd0, r_out_event.text_char, r_out_event.amount,
                            r_out_event.key_or_id, r_out_event.channel};

    // checks
    a_status_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_byte[7] |-> !dec_event.valid)
        else $error("status byte produced an event");

    a_ascii_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == mss_pkg::KIND_ASCII
        |-> m_axis_tdata[17:0] == 18'd0)
        else $error("ascii event carries midi fields");

    a_midi_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != mss_pkg::KIND_ASCII
        |-> m_axis_tdata[24:18] == 7'd0)
        else $error("midi event carries a character");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready
        |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

// ===== hdl/mss_parser.sv =====
// ----------------------------------------------------------------------------
// mss_parser
// Message assembly state and per-byte decode; gives at most one event per
// byte, combinationally from the byte and the held message state.
// ----------------------------------------------------------------------------
module mss_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [7:0]       i_byte,
    input  logic [3:0]       i_control_channel,
    output mss_pkg::t_event  o_event
);

    logic [7:0] r_status_hold;
    logic [7:0] n_status_hold;
    logic [6:0] r_first_data;
    logic [6:0] n_first_data;
    logic [1:0] r_fill_count;
    logic [1:0] n_fill_count;

    // report a completed message, or nothing
    function automatic mss_pkg::t_event finish(input logic [7:0] status,
                                               input logic [3:0] ctrl_ch,
                                               input logic [6:0] d1,
                                               input logic [6:0] d2);
        mss_pkg::t_event ev;
        ev           = '0;
        ev.channel   = status[3:0];
        ev.key_or_id = d1;
        if (status[7:4] == mss_pkg::STATUS_NOTE_ON) begin
            ev.valid  = 1'b1;
            ev.kind   = mss_pkg::KIND_START;
            ev.amount = d2;
        end else if (status[7:4] == mss_pkg::STATUS_NOTE_OFF) begin
            ev.valid  = 1'b1;
            ev.kind   = mss_pkg::KIND_STOP;
        end else if (status[7:4] == mss_pkg::STATUS_CTRL && status[3:0] == ctrl_ch) begin
            ev.valid  = 1'b1;
            ev.kind   = mss_pkg::KIND_CTRL;
            ev.amount = d2;
        end else begin
            ev = '0;
        end
        return ev;
    endfunction

    // next state and event for the byte in the input register
    always_comb begin
        n_status_hold = r_status_hold;
        n_first_data  = r_first_data;
        n_fill_count  = r_fill_count;
        o_event       = '0;
        if (i_advance) begin
            if (i_byte[7]) begin
                // status byte starts a message, drops any partial one
                n_status_hold = i_byte;
                n_fill_count  = mss_pkg::FILL_STATUS;
            end else begin
                case (r_fill_count)
                    mss_pkg::FILL_IDLE: begin
                        o_event.valid     = 1'b1;
                        o_event.kind      = mss_pkg::KIND_ASCII;
                        o_event.text_char = i_byte[6:0];
                    end
                    mss_pkg::FILL_STATUS: begin
                        n_first_data = i_byte[6:0];
                        if (r_status_hold[7:4] == mss_pkg::STATUS_CHAN_PRES) begin
                            n_fill_count = mss_pkg::FILL_IDLE;
                            o_event = finish(r_status_hold, i_control_channel,
                                             i_byte[6:0], 7'd0);
                        end else begin
                            n_fill_count = mss_pkg::FILL_FIRST;
                        end
                    end
                    default: begin
                        // second data byte completes a three-byte message
                        n_fill_count = mss_pkg::FILL_IDLE;
                        o_event = finish(r_status_hold, i_control_channel,
                                         r_first_data, i_byte[6:0]);
                    end
                endcase
            end
        end
    end

    // message state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status_hold <= '0;
            r_first_data  <= '0;
            r_fill_count  <= mss_pkg::FILL_IDLE;
        end else begin
            r_status_hold <= n_status_hold;
            r_first_data  <= n_first_data;
            r_fill_count  <= n_fill_count;
        end
    end

endmodule
